>>> sv/ils_pkg.sv
// Shared types and codes for the indexed LIFO stack.
package ils_pkg;

	localparam int CNT_W  = 5;
	localparam int WORD_W = 32;
	localparam int POS_W  = 4;

	localparam logic [1:0] MODE_PUSH   = 2'd0;
	localparam logic [1:0] MODE_POP    = 2'd1;
	localparam logic [1:0] MODE_PEEK   = 2'd2;
	localparam logic [1:0] MODE_CHANGE = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_BADPOS   = 2'd3;

	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic [1:0]              mode;
		logic [POS_W-1:0]        position;
		logic signed [WORD_W-1:0] data_in;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] data_out;
		logic [1:0]              status;
		logic [CNT_W-1:0]        entry_count;
		logic                    is_empty;
		logic                    is_full;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic exec;
	} cmd_t;

endpackage

>>> sv/ils_req_if.sv
// Request channel: valid, ready and one request beat.
interface ils_req_if import ils_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/ils_rsp_if.sv
// Result channel: valid, ready and one result beat.
interface ils_rsp_if import ils_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/ils_cfg_if.sv
// Configuration write channel carrying the capacity register.
interface ils_cfg_if import ils_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/ils_ctrl.sv
// Controller: sequences capture and execute of one request and owns the result valid.
module ils_ctrl import ils_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic out_free;

	assign in_ready    = (state_q == S_IDLE);
	assign out_free    = !out_valid_q || out_ready;
	assign cmd.capture = in_valid && in_ready;
	assign cmd.exec    = (state_q == S_EXEC) && out_free;
	assign out_valid   = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.capture) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

>>> sv/ils_dp.sv
// Datapath: entry store, fill level, capacity register and result register.
module ils_dp import ils_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  req_t             req,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_data,
	output rsp_t             rsp
);

	// Capacity is a 5-bit register, so no more than 31 entries can ever be used.
	localparam int STORE = (DEPTH < 31) ? DEPTH : 31;
	localparam int IDX_W = (STORE > 1) ? $clog2(STORE) : 1;
	localparam logic [CNT_W-1:0] STORE_CAP = CNT_W'(STORE);

	logic signed [WORD_W-1:0] mem [STORE];
	logic signed [WORD_W-1:0] rd_q;
	logic [CNT_W-1:0]         fill_q;
	logic [CNT_W-1:0]         cap_q;
	req_t                     req_s1;
	rsp_t                     rsp_q;

	logic [CNT_W-1:0]         raddr;
	logic [CNT_W-1:0]         cap_eff;
	logic [CNT_W-1:0]         pos_ext;
	logic [CNT_W-1:0]         fill_d;
	logic                     wr_en;
	logic [CNT_W-1:0]         waddr;
	logic signed [WORD_W-1:0] result;
	logic [1:0]               status;

	assign raddr   = (req.mode == MODE_POP) ? fill_q - CNT_W'(1)
	                                        : {1'b0, req.position};
	assign cap_eff = (cap_q > STORE_CAP) ? STORE_CAP : cap_q;
	assign pos_ext = {1'b0, req_s1.position};

	// Entries at or above the fill level are not cleared; a peek there reads as
	// zero because the result is taken from the store only below the fill level.
	always_comb begin
		fill_d = fill_q;
		wr_en  = 1'b0;
		waddr  = fill_q;
		result = '0;
		status = ST_OK;
		case (req_s1.mode)
			MODE_PUSH: begin
				if (fill_q >= cap_eff) begin
					status = ST_OVERFLOW;
				end else begin
					wr_en  = 1'b1;
					fill_d = fill_q + CNT_W'(1);
				end
			end
			MODE_POP: begin
				if (fill_q == '0) begin
					status = ST_EMPTY;
				end else begin
					fill_d = fill_q - CNT_W'(1);
					result = rd_q;
				end
			end
			MODE_PEEK: begin
				if (fill_q == '0) status = ST_EMPTY;
				else if (pos_ext >= cap_eff) status = ST_BADPOS;
				else if (pos_ext < fill_q) result = rd_q;
			end
			default: begin
				waddr = pos_ext;
				if (fill_q == '0) status = ST_EMPTY;
				else if (pos_ext >= fill_q) status = ST_BADPOS;
				else wr_en = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_q   <= mem[raddr[IDX_W-1:0]];
			req_s1 <= req;
		end
		if (cmd.exec && wr_en) mem[waddr[IDX_W-1:0]] <= req_s1.data_in;
		if (cmd.exec) begin
			rsp_q.data_out    <= result;
			rsp_q.status      <= status;
			rsp_q.entry_count <= fill_d;
			rsp_q.is_empty    <= (fill_d == '0);
			rsp_q.is_full     <= (fill_d >= cap_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			cap_q  <= CAP_RESET;
		end else begin
			if (cmd.exec) fill_q <= fill_d;
			if (cfg_we) cap_q <= cfg_data;
		end
	end

	assign rsp = rsp_q;

endmodule

>>> sv/indexed_lifo_stack.sv
// Top level of the indexed LIFO stack: controller plus datapath.
//
//   channel  modport  beat
//   req      sink     mode, position, data_in
//   rsp      source   data_out, status, entry_count, is_empty, is_full
//   cfg      sink     capacity (always ready)
//
// A request is captured, reading the single store port into a register,
// then executed, updating the fill level, store and result register.
// A new request is taken while the previous result still waits; execution
// stalls while the result register is full and rsp.ready is low.
// Reset clears the fill level and sets capacity to 16; the store needs no
// clearing pass because entries above the fill level read as zero.
module indexed_lifo_stack import ils_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic      clk,
	input logic      arst_n,
	ils_req_if.sink  req,
	ils_rsp_if.source rsp,
	ils_cfg_if.sink  cfg
);

	cmd_t cmd;

	assign cfg.ready = 1'b1;

	ils_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	ils_dp #(.DEPTH(DEPTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req.data),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.data),
		.rsp      (rsp.data)
	);

endmodule

>>> tb/sv/indexed_lifo_stack_tb.sv
// Self-checking testbench for the indexed LIFO stack: directed table, random phases, predictor.
module indexed_lifo_stack_tb;
	import ils_pkg::*;

	localparam int STACK_DEPTH = 16;
	localparam int CYCLE_LIMIT = 100000;
	localparam int IDLE_PCT    = 21;

	typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		req_t      req;
		bit        typed;
		rsp_t      want;
	} script_row_t;

	logic clk;
	logic arst_n;

	ils_req_if req_bus ();
	ils_rsp_if rsp_bus ();
	ils_cfg_if cfg_bus ();

	indexed_lifo_stack #(.DEPTH(STACK_DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	// Shadow copy of the stack, advanced once per accepted request beat.
	logic [CNT_W-1:0]         model_cap;
	logic [CNT_W-1:0]         model_level;
	logic signed [WORD_W-1:0] model_words [STACK_DEPTH];

	rsp_t        awaited_rsp [$];
	script_row_t script [$];
	int          mismatch_count = 0;
	int          cycles = 0;
	bit          steady_run;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic rsp_t stack_apply(input req_t r);
		rsp_t             o;
		logic [CNT_W-1:0] lim;
		lim = (model_cap > CNT_W'(STACK_DEPTH)) ? CNT_W'(STACK_DEPTH) : model_cap;
		o = '0;
		o.status = ST_OK;
		if (r.mode == MODE_PUSH) begin
			if (model_level >= lim) begin
				o.status = ST_OVERFLOW;
			end else begin
				model_words[model_level] = r.data_in;
				model_level++;
			end
		end else if (model_level == '0) begin
			// The empty check wins over any position check.
			o.status = ST_EMPTY;
		end else if (r.mode == MODE_POP) begin
			model_level--;
			o.data_out = model_words[model_level];
			model_words[model_level] = '0;
		end else if (r.mode == MODE_PEEK) begin
			if (r.position >= lim)
				o.status = ST_BADPOS;
			else
				o.data_out = model_words[r.position];
		end else begin
			if (r.position >= model_level)
				o.status = ST_BADPOS;
			else
				model_words[r.position] = r.data_in;
		end
		o.entry_count = model_level;
		o.is_empty    = (model_level == '0);
		o.is_full     = (model_level >= lim);
		return o;
	endfunction

	function automatic void add_row(input row_kind_t k, input int m,
			input int p, input logic signed [WORD_W-1:0] d, input int t,
			input logic signed [WORD_W-1:0] w_data, input int w_status,
			input int w_count, input int w_empty, input int w_full);
		script_row_t row;
		row.kind             = k;
		row.req.mode         = 2'(m);
		row.req.position     = POS_W'(p);
		row.req.data_in      = d;
		row.typed            = (t != 0);
		row.want.data_out    = w_data;
		row.want.status      = 2'(w_status);
		row.want.entry_count = CNT_W'(w_count);
		row.want.is_empty    = (w_empty != 0);
		row.want.is_full     = (w_full != 0);
		script.push_back(row);
	endfunction

	task automatic flag_mismatch(input string what);
		if (mismatch_count < 40)
			$display("MISMATCH @%0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic send_req(input req_t r, input bit typed, input rsp_t want);
		rsp_t predicted;
		while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.data  <= r;
		do @(posedge clk); while (!req_bus.ready);
		predicted = stack_apply(r);
		awaited_rsp.push_back(typed ? want : predicted);
	endtask

	// Holds the sender until every outstanding result beat has been taken.
	task automatic drain_rsp();
		req_bus.valid <= 1'b0;
		while (awaited_rsp.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CNT_W-1:0] cap);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= cap;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		model_cap = cap;
	endtask

	task automatic run_random(input int n, input logic [CNT_W-1:0] cap);
		req_t r;
		rsp_t none;
		int   span;
		int   roll;
		bit   lean_push;
		none = '0;
		drain_rsp();
		write_capacity(cap);
		span = 0;
		lean_push = 1'($urandom_range(0, 1));
		for (int i = 0; i < n; i++) begin
			if (i == n / 2)
				drain_rsp();
			// Alternate push-heavy and pop-heavy runs so the fill level sweeps its range.
			if (span == 0) begin
				lean_push = !lean_push;
				span = $urandom_range(10, 30);
			end
			span--;
			roll = $urandom_range(0, 99);
			if (lean_push)
				r.mode = roll < 70 ? MODE_PUSH : roll < 80 ? MODE_POP :
					roll < 90 ? MODE_PEEK : MODE_CHANGE;
			else
				r.mode = roll < 15 ? MODE_PUSH : roll < 55 ? MODE_POP :
					roll < 78 ? MODE_PEEK : MODE_CHANGE;
			if ($urandom_range(0, 3) != 0 && model_level != '0)
				r.position = POS_W'($urandom_range(0, model_level > 15 ? 15 : model_level));
			else
				r.position = POS_W'($urandom_range(0, 15));
			case ($urandom_range(0, 7))
				0: begin
					r.data_in = 32'sh8000_0000;
				end
				1: begin
					r.data_in = 32'sh7fff_ffff;
				end
				2: begin
					r.data_in = -32'sd1;
				end
				default: begin
					r.data_in = $urandom;
				end
			endcase
			send_req(r, 1'b0, none);
		end
	endtask

	initial begin
		rsp_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_bus.ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		rsp_t exp_r;
		if (rsp_bus.valid && rsp_bus.ready) begin
			if (awaited_rsp.size() == 0) begin
				flag_mismatch("result beat arrived with nothing pending");
			end else begin
				exp_r = awaited_rsp.pop_front();
				if (rsp_bus.data.data_out !== exp_r.data_out)
					flag_mismatch($sformatf("data_out %0d, want %0d",
						rsp_bus.data.data_out, exp_r.data_out));
				if (rsp_bus.data.status !== exp_r.status)
					flag_mismatch($sformatf("status %0d, want %0d",
						rsp_bus.data.status, exp_r.status));
				if (rsp_bus.data.entry_count !== exp_r.entry_count)
					flag_mismatch($sformatf("entry_count %0d, want %0d",
						rsp_bus.data.entry_count, exp_r.entry_count));
				if (rsp_bus.data.is_empty !== exp_r.is_empty)
					flag_mismatch($sformatf("is_empty %b, want %b",
						rsp_bus.data.is_empty, exp_r.is_empty));
				if (rsp_bus.data.is_full !== exp_r.is_full)
					flag_mismatch($sformatf("is_full %b, want %b",
						rsp_bus.data.is_full, exp_r.is_full));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		req_bus.valid  = 1'b0;
		req_bus.data   = '0;
		cfg_bus.valid  = 1'b0;
		cfg_bus.data   = CAP_RESET;
		steady_run     = 1'b0;
		model_cap      = CAP_RESET;
		model_level    = '0;
		foreach (model_words[i])
			model_words[i] = '0;

		// For configuration rows the capacity travels in data_in.
		add_row(ROW_REQ, MODE_POP,    0,  0,             1, 0,             ST_EMPTY,    0, 1, 0);
		add_row(ROW_REQ, MODE_PEEK,   15, 0,             1, 0,             ST_EMPTY,    0, 1, 0);
		add_row(ROW_REQ, MODE_CHANGE, 0,  5,             1, 0,             ST_EMPTY,    0, 1, 0);
		add_row(ROW_REQ, MODE_PUSH,   0,  32'sh8000_0000, 1, 0,            ST_OK,       1, 0, 0);
		add_row(ROW_REQ, MODE_PUSH,   9,  32'sh7fff_ffff, 1, 0,            ST_OK,       2, 0, 0);
		add_row(ROW_REQ, MODE_PEEK,   0,  0,             1, 32'sh8000_0000, ST_OK,      2, 0, 0);
		add_row(ROW_REQ, MODE_PEEK,   15, 0,             0, 0,             ST_OK,       0, 0, 0);
		add_row(ROW_REQ, MODE_CHANGE, 2,  11,            1, 0,             ST_BADPOS,   2, 0, 0);
		add_row(ROW_REQ, MODE_CHANGE, 1,  -1,            0, 0,             ST_OK,       0, 0, 0);
		add_row(ROW_REQ, MODE_POP,    0,  0,             0, 0,             ST_OK,       0, 0, 0);
		add_row(ROW_REQ, MODE_PEEK,   1,  0,             0, 0,             ST_OK,       0, 0, 0);
		add_row(ROW_CFG, MODE_PUSH,   0,  1,             0, 0,             ST_OK,       0, 0, 0);
		add_row(ROW_REQ, MODE_PUSH,   0,  123,           1, 0,             ST_OVERFLOW, 1, 0, 1);
		add_row(ROW_REQ, MODE_PEEK,   1,  0,             1, 0,             ST_BADPOS,   1, 0, 1);
		add_row(ROW_REQ, MODE_PEEK,   0,  0,             0, 0,             ST_OK,       0, 0, 0);
		add_row(ROW_CFG, MODE_PUSH,   0,  0,             0, 0,             ST_OK,       0, 0, 0);
		add_row(ROW_REQ, MODE_PEEK,   0,  0,             0, 0,             ST_OK,       0, 0, 0);
		add_row(ROW_REQ, MODE_CHANGE, 0,  77,            0, 0,             ST_OK,       0, 0, 0);
		add_row(ROW_REQ, MODE_POP,    0,  0,             0, 0,             ST_OK,       0, 0, 0);
		add_row(ROW_REQ, MODE_PUSH,   0,  1,             1, 0,             ST_OVERFLOW, 0, 1, 1);
		add_row(ROW_CFG, MODE_PUSH,   0,  31,            0, 0,             ST_OK,       0, 0, 0);
		add_row(ROW_REQ, MODE_PUSH,   0,  0,             0, 0,             ST_OK,       0, 0, 0);
		add_row(ROW_REQ, MODE_CHANGE, 15, 42,            0, 0,             ST_OK,       0, 0, 0);
		add_row(ROW_REQ, MODE_PEEK,   15, 0,             0, 0,             ST_OK,       0, 0, 0);
		add_row(ROW_REQ, MODE_POP,    0,  0,             0, 0,             ST_OK,       0, 0, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG) begin
				drain_rsp();
				write_capacity(script[i].req.data_in[CNT_W-1:0]);
			end else begin
				send_req(script[i].req, script[i].typed, script[i].want);
			end
		end

		run_random(50, 5'd16);
		run_random(50, 5'd31);
		run_random(50, 5'd3);
		run_random(50, 5'd1);
		run_random(50, 5'd0);
		steady_run = 1'b1;
		run_random(50, 5'd16);
		steady_run = 1'b0;
		run_random(50, CNT_W'($urandom_range(2, 15)));
		run_random(50, CNT_W'($urandom_range(17, 30)));
		run_random(50, CNT_W'($urandom_range(0, 31)));

		drain_rsp();
		repeat (10) @(posedge clk);
		if (awaited_rsp.size() != 0)
			flag_mismatch("expected results left over at the end");
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
